/* hdl/fprc_pkg.sv */
// Failed-page registry package: sizes, command codes, the key builder and
// the controller/datapath link types. No dependencies.

package fprc_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int PAGE_BITS  = 12;
  localparam int PAGE_SIZE  = 4096;

  localparam int OFF_W     = 51;
  localparam int LEN_W     = 13;
  localparam int KEY_W     = 63;
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int ENTRIES_W = 5;
  localparam int TALLY_W   = 32;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [SLOT_COUNT-1:0] slot_vec_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fsm_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rsp_free;
  } dp_sts_t;

  // Offset goes above the page bits; a short length fills the low bits.
  function automatic key_t make_key(input logic [OFF_W-1:0] off,
                                    input logic [LEN_W-1:0] len);
    key_t key;
    key = KEY_W'({off, {PAGE_BITS{1'b0}}});
    if (32'(len) < 32'(PAGE_SIZE)) begin
      key = key | KEY_W'(len);
    end
    return key;
  endfunction

endpackage

/* hdl/fprc_req_if.sv */
// Request channel of the failed-page registry: valid/ready and one item.
// Depends on fprc_pkg.

interface fprc_req_if
  import fprc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  cmd_e                 command;
  logic [OFF_W-1:0]     page_offset;
  logic [LEN_W-1:0]     page_length;

  modport source (output valid, command, page_offset, page_length, input ready);
  modport sink   (input valid, command, page_offset, page_length, output ready);
endinterface

/* hdl/fprc_rsp_if.sv */
// Response channel of the failed-page registry: valid/ready and one result.
// Depends on fprc_pkg.

interface fprc_rsp_if
  import fprc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 success;
  logic [ENTRIES_W-1:0] entries_held;
  logic [TALLY_W-1:0]   errors_seen;
  logic [TALLY_W-1:0]   fixes_seen;

  modport source (output valid, success, entries_held, errors_seen, fixes_seen,
                  input ready);
  modport sink   (input valid, success, entries_held, errors_seen, fixes_seen,
                  output ready);
endinterface

/* hdl/failed_page_registry_cam_top.sv */
// Failed-page registry top level: joins controller and datapath to the
// request and response channels. Depends on fprc_pkg, fprc_req_if,
// fprc_rsp_if, fprc_ctrl and fprc_dp.
//
// Usage:
//   req_i carries one item per handshake: command (add, delete, query,
//   clear), page offset and page length. rsp_o returns exactly one result
//   per item: success flag, occupied slot count and the error and fix tallies.
//   An item is captured on acceptance and executed once the response register
//   is free: all 16 slots are compared against the key at once, the lowest
//   free slot is picked and the result is written to the response register.
//   The controller alternates capture and execute steps around the slot
//   compare, so no new item is accepted before the last one has executed.
//   When the receiver stalls, the result waits in the response register and
//   the block still accepts one more item; that item is held in its execute
//   step until the waiting result is taken.
//   Reset empties the set and zeroes both tallies at once; the block is
//   ready for an item as soon as reset is released.

module failed_page_registry_cam_top
  import fprc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fprc_req_if.sink   req_i,
  fprc_rsp_if.source rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  fprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  fprc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .command_i      (req_i.command),
    .page_offset_i  (req_i.page_offset),
    .page_length_i  (req_i.page_length),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .success_o      (rsp_o.success),
    .entries_held_o (rsp_o.entries_held),
    .errors_seen_o  (rsp_o.errors_seen),
    .fixes_seen_o   (rsp_o.fixes_seen)
  );

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready
  ) else $error("request taken while an item is still in work");

  a_rsp_from_execute : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(dp_cmd.execute)
  ) else $error("response raised without an execute step");

  a_no_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !dp_cmd.execute
  ) else $error("execute overwrote a waiting response");

  a_count_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (32'(rsp_o.entries_held) <= SLOT_COUNT)
  ) else $error("slot count beyond capacity");

endmodule

/* hdl/fprc_ctrl.sv */
// Failed-page registry controller: two-state sequencer that captures an item
// and then executes it once the response register can take the result.
// Depends on fprc_pkg.

module fprc_ctrl
  import fprc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // take nothing while reset is held
        req_ready_o   = rst_ni;
        cmd_o.capture = req_valid_i && rst_ni;
      end
      ST_EXEC: begin
        // hold the item until the previous result has gone
        cmd_o.execute = sts_i.rsp_free;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/fprc_dp.sv */
// Failed-page registry datapath: item register, key slots with valid bits,
// parallel match, lowest-free-slot pick, tallies and the response register.
// Depends on fprc_pkg.

module fprc_dp
  import fprc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  cmd_e                 command_i,
  input  logic [OFF_W-1:0]     page_offset_i,
  input  logic [LEN_W-1:0]     page_length_i,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output logic                 success_o,
  output logic [ENTRIES_W-1:0] entries_held_o,
  output logic [TALLY_W-1:0]   errors_seen_o,
  output logic [TALLY_W-1:0]   fixes_seen_o
);

  cmd_e                 op_q;
  key_t                 key_q;
  key_t                 slot_key_q [SLOT_COUNT];
  slot_vec_t            used_q, used_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TALLY_W-1:0]   err_q, err_d;
  logic [TALLY_W-1:0]   fix_q, fix_d;
  slot_vec_t            hit_vec, free_oh, slot_we;
  logic                 hit_any, free_any, success_d;
  logic                 rsp_valid_q;
  logic                 success_q;
  logic [ENTRIES_W-1:0] entries_q;
  logic [TALLY_W-1:0]   err_out_q, fix_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= command_i;
      key_q <= make_key(page_offset_i, page_length_i);
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = used_q[i] && (slot_key_q[i] == key_q);
    end
    // isolate the lowest clear bit
    free_oh  = ~used_q & (used_q + SLOT_COUNT'(1));
    hit_any  = |hit_vec;
    free_any = |free_oh;
  end

  always_comb begin
    used_d    = used_q;
    count_d   = count_q;
    err_d     = err_q;
    fix_d     = fix_q;
    success_d = 1'b0;
    slot_we   = '0;
    if (cmd_i.execute) begin
      case (op_q)
        CMD_ADD: begin
          err_d = err_q + TALLY_W'(1);
          if (hit_any) begin
            success_d = 1'b1;
          end else if (free_any) begin
            slot_we   = free_oh;
            used_d    = used_q | free_oh;
            count_d   = count_q + CNT_W'(1);
            success_d = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (hit_any) begin
            used_d    = used_q & ~hit_vec;
            count_d   = (count_q != '0) ? count_q - CNT_W'(1) : count_q;
            fix_d     = fix_q + TALLY_W'(1);
            success_d = 1'b1;
          end
        end
        CMD_QUERY: begin
          success_d = hit_any;
        end
        CMD_CLEAR: begin
          used_d    = '0;
          count_d   = '0;
          err_d     = '0;
          fix_d     = '0;
          success_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_we[i]) begin
        slot_key_q[i] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      err_q   <= '0;
      fix_q   <= '0;
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
      err_q   <= err_d;
      fix_q   <= fix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      success_q <= success_d;
      entries_q <= ENTRIES_W'(count_d);
      err_out_q <= err_d;
      fix_out_q <= fix_d;
    end
  end

  assign sts_o.rsp_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign success_o      = success_q;
  assign entries_held_o = entries_q;
  assign errors_seen_o  = err_out_q;
  assign fixes_seen_o   = fix_out_q;

endmodule

/* sim/tb_failed_page_registry_cam_top.sv */
`timescale 1ns / 100ps
// Testbench for failed_page_registry_cam_top: a directed table of page items and then
// random add/delete/query/clear traffic, checked against pinned results or a behavioural set.
// Depends on fprc_pkg, fprc_req_if, fprc_rsp_if and the registry RTL.

module tb_failed_page_registry_cam_top;
  import fprc_pkg::*;

  localparam int POOL_SIZE = 24;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  typedef struct packed {
    logic                 success;
    logic [ENTRIES_W-1:0] entries_held;
    logic [TALLY_W-1:0]   errors_seen;
    logic [TALLY_W-1:0]   fixes_seen;
  } page_outcome_t;

  typedef struct {
    cmd_e             command;
    logic [OFF_W-1:0] page_offset;
    logic [LEN_W-1:0] page_length;
    bit               pinned;
    page_outcome_t    want;
  } page_row_t;

  logic clk;
  logic rst_n;

  fprc_req_if req_if ();
  fprc_rsp_if rsp_if ();

  failed_page_registry_cam_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the failed-page set
  key_t               held_key [SLOT_COUNT];
  bit                 held_used [SLOT_COUNT];
  int unsigned        held_count;
  logic [TALLY_W-1:0] add_tally;
  logic [TALLY_W-1:0] fix_tally;

  page_outcome_t    outcome_q [$];
  page_row_t        directed_rows [$];
  int unsigned      fault_count;
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  logic [OFF_W-1:0] pool_off [POOL_SIZE];
  logic [LEN_W-1:0] pool_len [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic key_t page_key(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
    key_t k;
    k = key_t'(off) << PAGE_BITS;
    // a short last page keeps its length in the low bits
    if (len < LEN_W'(PAGE_SIZE)) begin
      k = k | key_t'(len);
    end
    return k;
  endfunction

  function automatic int find_slot(input key_t k);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (held_used[i] && held_key[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void clear_set();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      held_key[i]  = '0;
      held_used[i] = 1'b0;
    end
    held_count = 0;
    add_tally  = '0;
    fix_tally  = '0;
  endfunction

  function automatic page_outcome_t apply_page(input cmd_e c, input logic [OFF_W-1:0] off,
                                               input logic [LEN_W-1:0] len);
    key_t          k;
    int            hit;
    int            i;
    bit            ok;
    page_outcome_t r;
    k  = page_key(off, len);
    ok = 1'b0;
    case (c)
      CMD_ADD: begin
        add_tally = add_tally + 1'b1;
        hit = find_slot(k);
        if (hit >= 0) begin
          ok = 1'b1;
        end else begin
          // take the lowest free slot; a full set leaves the slots as they are
          for (i = 0; i < SLOT_COUNT; i++) begin
            if (!held_used[i]) begin
              held_key[i]  = k;
              held_used[i] = 1'b1;
              held_count++;
              ok = 1'b1;
              break;
            end
          end
        end
      end
      CMD_DELETE: begin
        hit = find_slot(k);
        if (hit >= 0) begin
          held_used[hit] = 1'b0;
          held_key[hit]  = '0;
          if (held_count > 0) held_count--;
          fix_tally = fix_tally + 1'b1;
          ok = 1'b1;
        end
      end
      CMD_QUERY: begin
        ok = (find_slot(k) >= 0);
      end
      default: begin
        clear_set();
        ok = 1'b1;
      end
    endcase
    r.success      = ok;
    r.entries_held = ENTRIES_W'(held_count);
    r.errors_seen  = add_tally;
    r.fixes_seen   = fix_tally;
    return r;
  endfunction

  function automatic void add_row(input cmd_e c, input logic [OFF_W-1:0] off,
                                  input logic [LEN_W-1:0] len, input bit pinned,
                                  input page_outcome_t want);
    page_row_t row;
    row.command     = c;
    row.page_offset = off;
    row.page_length = len;
    row.pinned      = pinned;
    row.want        = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [OFF_W-1:0] random_offset();
    return OFF_W'({$urandom(), $urandom()});
  endfunction

  // Offer one item, idling first at the sender's rate; record the expectation on acceptance.
  task automatic offer_page(input cmd_e c, input logic [OFF_W-1:0] off,
                            input logic [LEN_W-1:0] len, input bit pinned,
                            input page_outcome_t want);
    page_outcome_t got;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= c;
    req_if.page_offset <= off;
    req_if.page_length <= len;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    got = apply_page(c, off, len);
    outcome_q.push_back(pinned ? want : got);
  endtask

  // Mostly commands on a small pool of pages so that hits, refills and a full set happen often.
  task automatic random_pages(input int unsigned count);
    int unsigned      r;
    int unsigned      p;
    cmd_e             c;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < POOL_SIZE; i++) begin
      // pair some pages at one offset: short and full page must stay distinct
      pool_off[i] = (i % 2 == 1 && $urandom_range(1)) ? pool_off[i-1] : random_offset();
      pool_len[i] = $urandom_range(1) ? LEN_W'($urandom_range(4095))
                                      : LEN_W'($urandom_range(8191, 4096));
    end
    repeat (count) begin
      r   = $urandom_range(99);
      p   = $urandom_range(POOL_SIZE - 1);
      off = pool_off[p];
      len = pool_len[p];
      if (r < 3) begin
        c = CMD_CLEAR;
      end else if (r < 45) begin
        c = CMD_ADD;
      end else if (r < 70) begin
        c = CMD_DELETE;
      end else if (r < 92) begin
        c = CMD_QUERY;
      end else begin
        c   = cmd_e'($urandom_range(3));
        off = random_offset();
        len = LEN_W'($urandom_range(8191));
      end
      offer_page(c, off, len, 1'b0, '0);
    end
  endtask

  function automatic void report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic void check_outcome();
    page_outcome_t want;
    page_outcome_t seen;
    seen.success      = rsp_if.success;
    seen.entries_held = rsp_if.entries_held;
    seen.errors_seen  = rsp_if.errors_seen;
    seen.fixes_seen   = rsp_if.fixes_seen;
    if (outcome_q.size() == 0) begin
      report_fault($sformatf("result with no item outstanding: ok=%0d n=%0d err=%0d fix=%0d",
                             seen.success, seen.entries_held, seen.errors_seen,
                             seen.fixes_seen));
      return;
    end
    want = outcome_q.pop_front();
    if (seen.success !== want.success || seen.entries_held !== want.entries_held ||
        seen.errors_seen !== want.errors_seen || seen.fixes_seen !== want.fixes_seen) begin
      report_fault($sformatf("mismatch: want ok=%0d n=%0d err=%0d fix=%0d, got ok=%0d n=%0d err=%0d fix=%0d",
                             want.success, want.entries_held, want.errors_seen,
                             want.fixes_seen, seen.success, seen.entries_held,
                             seen.errors_seen, seen.fixes_seen));
    end
  endfunction

  // Result side: sample at the edge, then decide whether to stall the next cycle.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_outcome();
      rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("[failed_page_registry_cam_top] ERROR");
    $finish;
  end

  initial begin
    clear_set();
    fault_count = 0;
    idle_pct    = 6;
    stall_pct   = 49;
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.command     <= CMD_ADD;
    req_if.page_offset <= '0;
    req_if.page_length <= '0;

    add_row(CMD_QUERY,  '0,      13'd0,    1'b1, '{1'b0, 5'd0, 32'd0, 32'd0});
    add_row(CMD_DELETE, '0,      13'd0,    1'b1, '{1'b0, 5'd0, 32'd0, 32'd0});
    add_row(CMD_ADD,    '0,      13'd4096, 1'b1, '{1'b1, 5'd1, 32'd1, 32'd0});
    // zero length is short but lands on the same key as the full page
    add_row(CMD_ADD,    '0,      13'd0,    1'b1, '{1'b1, 5'd1, 32'd2, 32'd0});
    add_row(CMD_ADD,    '0,      13'd4095, 1'b1, '{1'b1, 5'd2, 32'd3, 32'd0});
    add_row(CMD_ADD,    OFF_MAX, 13'd8191, 1'b1, '{1'b1, 5'd3, 32'd4, 32'd0});
    add_row(CMD_QUERY,  OFF_MAX, 13'd5000, 1'b1, '{1'b1, 5'd3, 32'd4, 32'd0});
    add_row(CMD_DELETE, '0,      13'd4095, 1'b1, '{1'b1, 5'd2, 32'd4, 32'd1});
    add_row(CMD_QUERY,  '0,      13'd4095, 1'b1, '{1'b0, 5'd2, 32'd4, 32'd1});
    // fill the set with distinct pages
    for (int i = 1; i <= 14; i++) begin
      add_row(CMD_ADD, (OFF_W'(i) << 30) | OFF_W'($urandom_range(32'h3fff_ffff)),
              LEN_W'($urandom_range(8191)), 1'b0, '0);
    end
    add_row(CMD_ADD,    OFF_W'(15) << 30, 13'd100, 1'b1, '{1'b0, 5'd16, 32'd19, 32'd1});
    add_row(CMD_CLEAR,  OFF_MAX, 13'd8191, 1'b1, '{1'b1, 5'd0, 32'd0, 32'd0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_page(directed_rows[i].command, directed_rows[i].page_offset,
                 directed_rows[i].page_length, directed_rows[i].pinned, directed_rows[i].want);
    end
    random_pages(275);

    idle_pct  = 49;
    stall_pct = 6;
    random_pages(300);

    idle_pct  = 0;
    stall_pct = 0;
    random_pages(300);
    req_if.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fault_count == 0) begin
      $display("[failed_page_registry_cam_top] OK");
    end else begin
      $display("[failed_page_registry_cam_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fprc_pkg.sv
hdl/fprc_req_if.sv
hdl/fprc_rsp_if.sv
hdl/fprc_ctrl.sv
hdl/fprc_dp.sv
hdl/failed_page_registry_cam_top.sv
sim/tb_failed_page_registry_cam_top.sv
